### sv/vsl3_pkg.sv
// Shared types and constants for the 3D vector set-length pipeline.
`default_nettype none
package vsl3_pkg;

    localparam int W      = 32;
    localparam int SQ_W   = 64;
    localparam int N_SQRT = SQ_W / 2;
    localparam int N_DIV  = W;
    localparam int REM_W  = W + 1;

    // values carried alongside the root chain
    typedef struct packed {
        logic [2:0][SQ_W-1:0] p;
        logic [2:0]           dneg;
        logic                 lneg;
        logic                 zero;
        logic [W-1:0]         len;
    } side_t;

    // root state for one step
    typedef struct packed {
        logic [SQ_W-1:0] x;
        logic [SQ_W-1:0] res;
        logic [SQ_W-1:0] bitv;
    } sq_t;

    // flags carried through the divider chain
    typedef struct packed {
        logic [2:0]   dneg;
        logic         lneg;
        logic         zero;
        logic [W-1:0] len;
    } flag_t;

    // divider state for three lanes sharing one divisor
    typedef struct packed {
        logic [2:0][REM_W-1:0] r;
        logic [2:0][W-1:0]     low;
        logic [2:0][W-1:0]     q;
        logic [REM_W-1:0]      d;
    } div_t;

endpackage
`default_nettype wire

### sv/vector_set_length_3d_top.sv
// Top level of the 3D vector set-length pipeline.
// Usage:
//   Input channel s_valid/s_ready carries one word: a direction
//   (s_dir_x, s_dir_y, s_dir_z) and a signed length, all Q16.16.
//   Result channel m_valid/m_ready returns length * d / |d| per component,
//   rounded to nearest and saturated, with m_saturated set on any clip.
//   A zero direction returns (0, length, 0).
// Throughput: one word per cycle while the skid register is empty. A word
//   passes the front end (5 stages), the 32-cell root chain, one numerator
//   stage, the 32-cell divider chain and the output register to m_valid.
// Stalls: the whole pipeline advances together; an output register plus a
//   skid register let it keep accepting while one result waits. s_ready
//   drops only once the skid register is full.
// Reset: aresetn (synchronous, active low) clears all valid flags, which
//   empties the pipeline and raises s_ready.
`default_nettype none
module vector_set_length_3d_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_dir_x,
    input  wire logic [31:0] s_dir_y,
    input  wire logic [31:0] s_dir_z,
    input  wire logic [31:0] s_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_out_x,
    output logic [31:0]      m_out_y,
    output logic [31:0]      m_out_z,
    output logic             m_saturated
);
    localparam int W    = vsl3_pkg::W;
    localparam int SQW  = vsl3_pkg::SQ_W;
    localparam int NS   = vsl3_pkg::N_SQRT;
    localparam int ND   = vsl3_pkg::N_DIV;
    localparam int RW   = vsl3_pkg::REM_W;

    logic en;

    // stage 1: input capture
    logic              v1_reg;
    logic [2:0][W-1:0] d1_reg;
    logic [W-1:0]      l1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg <= {s_dir_z, s_dir_y, s_dir_x};
            l1_reg <= s_length;
        end
    end

    // stage 2: magnitudes and normalising shift count
    logic              v2_reg;
    logic [2:0][W-1:0] a2_reg, a2_next;
    logic [2:0]        dn2_reg;
    logic [W-1:0]      lm2_reg, lm2_next;
    logic              ln2_reg;
    logic [W-1:0]      len2_reg;
    logic [4:0]        sh2_reg, sh2_next;
    logic              z2_reg;
    logic [W-1:0]      mx;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a2_next[i] = d1_reg[i][W-1] ? (~d1_reg[i] + 1'b1) : d1_reg[i];
        end
        lm2_next = l1_reg[W-1] ? (~l1_reg + 1'b1) : l1_reg;
        mx = a2_next[0];
        if (a2_next[1] > mx) mx = a2_next[1];
        if (a2_next[2] > mx) mx = a2_next[2];
        sh2_next = '0;
        for (int b = 0; b < W - 2; b++) begin
            if (mx[b]) sh2_next = 5'(W - 2 - b);
        end
        // already in range: no shift
        if (mx[W-1] || mx[W-2]) sh2_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg   <= a2_next;
            dn2_reg  <= {d1_reg[2][W-1], d1_reg[1][W-1], d1_reg[0][W-1]};
            lm2_reg  <= lm2_next;
            ln2_reg  <= l1_reg[W-1];
            len2_reg <= l1_reg;
            sh2_reg  <= sh2_next;
            z2_reg   <= (mx == '0);
        end
    end

    // stage 3: apply the shift
    logic              v3_reg;
    logic [2:0][W-1:0] a3_reg;
    logic [2:0]        dn3_reg;
    logic [W-1:0]      lm3_reg;
    logic              ln3_reg, z3_reg;
    logic [W-1:0]      len3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) a3_reg[i] <= a2_reg[i] << sh2_reg;
            dn3_reg  <= dn2_reg;
            lm3_reg  <= lm2_reg;
            ln3_reg  <= ln2_reg;
            z3_reg   <= z2_reg;
            len3_reg <= len2_reg;
        end
    end

    // stage 4: squares and length products
    logic                v4_reg;
    logic [2:0][SQW-1:0] sq4_reg, p4_reg;
    logic [2:0]          dn4_reg;
    logic                ln4_reg, z4_reg;
    logic [W-1:0]        len4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= SQW'(a3_reg[i]) * SQW'(a3_reg[i]);
                p4_reg[i]  <= SQW'(lm3_reg) * SQW'(a3_reg[i]);
            end
            dn4_reg  <= dn3_reg;
            ln4_reg  <= ln3_reg;
            z4_reg   <= z3_reg;
            len4_reg <= len3_reg;
        end
    end

    // stage 5: sum of squares, seed the root chain
    logic            v5_reg;
    vsl3_pkg::sq_t   sq5_reg;
    vsl3_pkg::side_t sd5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq5_reg.x    <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2];
            sq5_reg.res  <= '0;
            sq5_reg.bitv <= SQW'(1) << (SQW - 2);
            sd5_reg.p    <= p4_reg;
            sd5_reg.dneg <= dn4_reg;
            sd5_reg.lneg <= ln4_reg;
            sd5_reg.zero <= z4_reg;
            sd5_reg.len  <= len4_reg;
        end
    end

    // root chain
    logic            sv  [NS+1];
    vsl3_pkg::sq_t   ssq [NS+1];
    vsl3_pkg::side_t ssd [NS+1];

    assign sv[0]  = v5_reg;
    assign ssq[0] = sq5_reg;
    assign ssd[0] = sd5_reg;

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        vsl3_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (sv[k]),
            .in_sq    (ssq[k]),
            .in_side  (ssd[k]),
            .out_valid(sv[k+1]),
            .out_sq   (ssq[k+1]),
            .out_side (ssd[k+1])
        );
    end

    // numerator and divisor stage
    logic            v6_reg;
    vsl3_pkg::div_t  dv6_reg;
    vsl3_pkg::flag_t fl6_reg;
    logic [SQW-1:0]  num [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = {ssd[NS].p[i][SQW-2:0], 1'b0} + ssq[NS].res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= sv[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dv6_reg.r[i]   <= RW'(num[i][SQW-1:W]);
                dv6_reg.low[i] <= num[i][W-1:0];
                dv6_reg.q[i]   <= '0;
            end
            dv6_reg.d     <= {ssq[NS].res[W-1:0], 1'b0};
            fl6_reg.dneg  <= ssd[NS].dneg;
            fl6_reg.lneg  <= ssd[NS].lneg;
            fl6_reg.zero  <= ssd[NS].zero;
            fl6_reg.len   <= ssd[NS].len;
        end
    end

    // divider chain
    logic            dvv [ND+1];
    vsl3_pkg::div_t  dvd [ND+1];
    vsl3_pkg::flag_t dvf [ND+1];

    assign dvv[0] = v6_reg;
    assign dvd[0] = dv6_reg;
    assign dvf[0] = fl6_reg;

    for (genvar k = 0; k < ND; k++) begin : g_div
        vsl3_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (dvv[k]),
            .in_div   (dvd[k]),
            .in_flag  (dvf[k]),
            .out_valid(dvv[k+1]),
            .out_div  (dvd[k+1]),
            .out_flag (dvf[k+1])
        );
    end

    // sign, saturate and the zero-direction case
    logic [2:0][W-1:0] res_c;
    logic              res_sat;
    logic [W-1:0]      qv;
    logic              neg;

    always_comb begin
        res_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            qv  = dvd[ND].q[i];
            neg = dvf[ND].lneg ^ dvf[ND].dneg[i];
            if (qv == '0) begin
                res_c[i] = '0;
            end else if (neg) begin
                res_c[i] = ~qv + 1'b1;
            end else if (qv[W-1]) begin
                res_c[i] = {1'b0, {(W-1){1'b1}}};
                res_sat  = 1'b1;
            end else begin
                res_c[i] = qv;
            end
        end
        if (dvf[ND].zero) begin
            res_c   = {{W{1'b0}}, dvf[ND].len, {W{1'b0}}};
            res_sat = 1'b0;
        end
    end

    // output register and skid register
    logic              out_valid_reg, skid_valid_reg;
    logic [2:0][W-1:0] out_c_reg, skid_c_reg;
    logic              out_sat_reg, skid_sat_reg;
    logic              incoming;

    assign en       = !skid_valid_reg;
    assign incoming = en && dvv[ND];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_ready) begin
            if (incoming) skid_valid_reg <= 1'b1;
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= incoming;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_ready) begin
            if (incoming) begin
                skid_c_reg   <= res_c;
                skid_sat_reg <= res_sat;
            end
        end else if (skid_valid_reg) begin
            out_c_reg   <= skid_c_reg;
            out_sat_reg <= skid_sat_reg;
        end else begin
            out_c_reg   <= res_c;
            out_sat_reg <= res_sat;
        end
    end

    assign s_ready     = en;
    assign m_valid     = out_valid_reg;
    assign m_out_x     = out_c_reg[0];
    assign m_out_y     = out_c_reg[1];
    assign m_out_z     = out_c_reg[2];
    assign m_saturated = out_sat_reg;

    // skid holds a word only behind a waiting output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // a finished word reaches the output
    a_word_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        incoming |=> (out_valid_reg || skid_valid_reg))
        else $error("finished word lost");

    // a clip always shows a limit value
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_out_x == 32'h7fffffff || m_out_y == 32'h7fffffff ||
             m_out_z == 32'h7fffffff))
        else $error("saturated flag without a limit value");
endmodule
`default_nettype wire

### sv/vsl3_sqrt_cell.sv
// One step of the integer square root chain.
`default_nettype none
module vsl3_sqrt_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire vsl3_pkg::sq_t  in_sq,
    input  wire vsl3_pkg::side_t in_side,
    output logic                out_valid,
    output vsl3_pkg::sq_t       out_sq,
    output vsl3_pkg::side_t     out_side
);
    logic                         valid_reg;
    vsl3_pkg::sq_t                sq_reg, sq_next;
    vsl3_pkg::side_t              side_reg;
    logic [vsl3_pkg::SQ_W-1:0]    trial;

    // try one root bit
    always_comb begin
        trial = in_sq.res + in_sq.bitv;
        if (in_sq.x >= trial) begin
            sq_next.x   = in_sq.x - trial;
            sq_next.res = (in_sq.res >> 1) + in_sq.bitv;
        end else begin
            sq_next.x   = in_sq.x;
            sq_next.res = in_sq.res >> 1;
        end
        sq_next.bitv = in_sq.bitv >> 2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg   <= sq_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_side  = side_reg;
endmodule
`default_nettype wire

### sv/vsl3_div_cell.sv
// One quotient bit of the three-lane restoring divider chain.
`default_nettype none
module vsl3_div_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire vsl3_pkg::div_t  in_div,
    input  wire vsl3_pkg::flag_t in_flag,
    output logic                 out_valid,
    output vsl3_pkg::div_t       out_div,
    output vsl3_pkg::flag_t      out_flag
);
    logic            valid_reg;
    vsl3_pkg::div_t  div_reg, div_next;
    vsl3_pkg::flag_t flag_reg;
    logic [vsl3_pkg::REM_W:0] t [3];
    logic [2:0]               ge;

    // shift in one dividend bit per lane and subtract where it fits
    always_comb begin
        div_next.d = in_div.d;
        for (int i = 0; i < 3; i++) begin
            t[i]  = {in_div.r[i], in_div.low[i][vsl3_pkg::W-1]};
            ge[i] = (t[i] >= {1'b0, in_div.d});
            if (ge[i]) begin
                div_next.r[i] = vsl3_pkg::REM_W'(t[i] - {1'b0, in_div.d});
            end else begin
                div_next.r[i] = vsl3_pkg::REM_W'(t[i]);
            end
            div_next.low[i] = {in_div.low[i][vsl3_pkg::W-2:0], 1'b0};
            div_next.q[i]   = {in_div.q[i][vsl3_pkg::W-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg  <= div_next;
            flag_reg <= in_flag;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_flag  = flag_reg;
endmodule
`default_nettype wire

### bench/tb_vector_set_length_3d_top.sv
// Self-checking bench for the 3D vector set-length pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb_vector_set_length_3d_top;

    localparam int LATENCY = 71;

    typedef struct {
        logic [31:0] dx, dy, dz, len;
        bit          known;
        logic [31:0] ex, ey, ez;
        logic        esat;
    } row_t;

    typedef struct {
        logic [31:0] x, y, z;
        logic        sat;
    } scaled_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_dir_x = '0, s_dir_y = '0, s_dir_z = '0, s_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_out_x, m_out_y, m_out_z;
    logic        m_saturated;

    scaled_t     pending_q[$];
    int          mismatches = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          hold_off = 0;
    int          hold_cnt = 0;
    logic        hold_taken = 1'b0;

    vector_set_length_3d_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .s_length(s_length),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_saturated(m_saturated)
    );

    always #4 aclk = ~aclk;

    // integer root of a 64-bit word
    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale direction to the requested length, round to nearest, saturate
    function automatic scaled_t scale_to_length(logic [31:0] dx, dy, dz, len);
        scaled_t     res;
        logic [63:0] a[3];
        logic [31:0] d[3];
        logic        dn[3];
        logic        ln, neg;
        logic [63:0] lm, m, s2, n, q;
        logic [127:0] num;
        logic [31:0] o[3];
        d[0] = dx; d[1] = dy; d[2] = dz;
        ln = len[31];
        lm = ln ? 64'(-$signed({len[31], len})) & 64'h1_FFFF_FFFF : 64'(len);
        lm = ln ? (64'd1 << 32) - 64'(len) : 64'(len);
        m = 0;
        res.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            dn[i] = d[i][31];
            a[i] = dn[i] ? (64'd1 << 32) - 64'(d[i]) : 64'(d[i]);
            if (a[i] > m) m = a[i];
        end
        if (m == 0) begin
            res.x = 0; res.y = len; res.z = 0;
            return res;
        end
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
        end
        s2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        n = int_root(s2);
        for (int i = 0; i < 3; i++) begin
            q = 0;
            if (a[i] != 0 && lm != 0) begin
                num = 128'(2) * lm * a[i] + n;
                q = 64'(num / (128'(2) * n));
            end
            neg = ln != dn[i];
            if (q == 0) o[i] = 0;
            else if (neg) begin
                if (q > 64'h8000_0000) begin
                    res.sat = 1'b1; o[i] = 32'h8000_0000;
                end else o[i] = 32'(-q);
            end else begin
                if (q > 64'h7FFF_FFFF) begin
                    res.sat = 1'b1; o[i] = 32'h7FFF_FFFF;
                end else o[i] = 32'(q);
            end
        end
        res.x = o[0]; res.y = o[1]; res.z = o[2];
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 ^ $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 512)) - 256);
            3: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'h80000);
            default: return $urandom;
        endcase
    endfunction

    // offer one word, hold until accepted
    task automatic offer_word(row_t r);
        scaled_t e;
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_dir_x  <= r.dx; s_dir_y <= r.dy; s_dir_z <= r.dz; s_length <= r.len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        e = scale_to_length(r.dx, r.dy, r.dz, r.len);
        if (r.known) begin
            e.x = r.ex; e.y = r.ey; e.z = r.ez; e.sat = r.esat;
        end
        pending_q.push_back(e);
    endtask

    // receiver: random stalls plus a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_off > 0 && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cnt   <= hold_off - 1;
            m_ready    <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
        end
    end

    // compare each returned word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                scaled_t e;
                e = pending_q.pop_front();
                if (e.x !== m_out_x || e.y !== m_out_y || e.z !== m_out_z ||
                    e.sat !== m_saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                                 e.x, e.y, e.z, e.sat,
                                 m_out_x, m_out_y, m_out_z, m_saturated);
                end
            end
        end
    end

    initial begin
        row_t dir_rows[$];
        row_t r;
        int   phase;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows; known results where obvious
        dir_rows = '{
            '{0, 0, 0, 32'h0001_0000, 1, 0, 32'h0001_0000, 0, 0},
            '{0, 0, 0, 32'h8000_0000, 1, 0, 32'h8000_0000, 0, 0},
            '{32'h0000_0001, 0, 0, 32'h0002_0000, 1, 32'h0002_0000, 0, 0, 0},
            '{0, 32'hFFFF_FFFF, 0, 32'h0003_0000, 1, 0, 32'hFFFD_0000, 0, 0},
            '{0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 32'h8000_0000, 0},
            '{0, 0, 32'h8000_0000, 32'h8000_0000, 1, 0, 0, 32'h7FFF_FFFF, 1},
            '{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 1, 32'h8000_0001, 0, 0, 0},
            '{32'h0001_0000, 0, 0, 0, 1, 0, 0, 0, 0},
            '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0,0,0,0,0},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,0,0,0,0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,0,0,0,0},
            '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 0,0,0,0,0},
            '{32'h0003_0000, 32'h0004_0000, 0, 32'hFFFB_0000, 0, 0, 0, 0, 0},
            '{32'h1234_5678, 32'hEDCB_A988, 32'h0000_0010, 32'h7FFF_FFFF, 0,0,0,0,0}
        };
        foreach (dir_rows[i]) offer_word(dir_rows[i]);

        // random phases with different idling mixes
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 60; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 60; end
                3: begin send_idle = 11; recv_stall = 11; end
                default: begin send_idle = 0; recv_stall = 0; hold_off = 300; end
            endcase
            repeat (150) begin
                r.dx = rand_word(); r.dy = rand_word(); r.dz = rand_word();
                r.len = rand_word(); r.known = 0;
                if ($urandom_range(0, 9) == 0) r.dx = 0;
                if ($urandom_range(0, 9) == 0) r.dy = 0;
                if ($urandom_range(0, 9) == 0) r.dz = 0;
                offer_word(r);
            end
            // sender pause until the pipeline drains
            s_valid <= 1'b0;
            while (pending_q.size() != 0) @(posedge aclk);
        end

        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit
    initial begin
        #(8 * 400000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
